[hw/rtl/bfm_pkg.sv]
// Shared types, constants and index helpers for the byte FIFO with message marks.
package bfm_pkg;

    // Storage geometry.
    localparam int STORE_DEPTH = 1024;
    localparam int MARK_DEPTH  = 16;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int MIDX_W      = $clog2(MARK_DEPTH);
    localparam int MCNT_W      = MIDX_W + 1;
    localparam int WORD_BYTES  = 4;
    localparam int MAX_LEN     = STORE_DEPTH - (STORE_DEPTH % WORD_BYTES);

    // Configuration port.
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int MARK_CFG_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_LENGTH = 2'd0,
        CFG_MARK_SLOTS  = 2'd1,
        CFG_WORD_ALIGN  = 2'd2
    } bfm_cfg_t;

    typedef enum logic [3:0] {
        OP_RESET         = 4'd0,
        OP_PUT           = 4'd1,
        OP_PUT_MARKED    = 4'd2,
        OP_MARK_HERE     = 4'd3,
        OP_GET           = 4'd4,
        OP_PEEK          = 4'd5,
        OP_SKIP_TO_MARK  = 4'd6,
        OP_DISCARD       = 4'd7,
        OP_TENT_BEGIN    = 4'd8,
        OP_TENT_BYTE     = 4'd9,
        OP_COMMIT        = 4'd10,
        OP_COMMIT_MARKED = 4'd11
    } bfm_op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_END_OF_MSG = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_FULL       = 3'd3,
        ST_MARKS_FULL = 3'd4,
        ST_NO_MARK    = 3'd5
    } bfm_status_t;

    typedef enum logic [1:0] {
        AL_NONE  = 2'd0,
        AL_READ  = 2'd1,
        AL_WRITE = 2'd2
    } bfm_align_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_ALIGN  = 2'd2,
        S_REPORT = 2'd3
    } bfm_state_t;

    typedef struct packed {
        logic [3:0]  operation;
        logic [7:0]  data_byte;
        logic [31:0] mark_tag;
    } bfm_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_byte;
        logic [31:0] out_tag;
        logic [9:0]  bytes_held;
        logic [9:0]  bytes_free;
        logic [3:0]  marks_held;
    } bfm_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic align;
        logic report;
    } bfm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic align_needed;
        logic out_free;
    } bfm_stat_t;

    // Advance a byte index by n positions around a ring of len bytes.
    function automatic logic [IDX_W-1:0] ring_adv(logic [IDX_W-1:0] i, logic [2:0] n,
                                                  logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] v;
        v = {1'b0, i} + LEN_W'(n);
        if (v >= len)
            v = v - len;
        return v[IDX_W-1:0];
    endfunction

    // Distance from b forward to a around a ring of len bytes.
    function automatic logic [IDX_W-1:0] ring_dist(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                                   logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] d;
        if (a >= b)
            d = {1'b0, a} - {1'b0, b};
        else
            d = {1'b0, a} + len - {1'b0, b};
        return d[IDX_W-1:0];
    endfunction

    // Distance from b forward to a around the mark ring; zero when marks are off.
    function automatic logic [MIDX_W-1:0] mark_dist(logic [MIDX_W-1:0] a, logic [MIDX_W-1:0] b,
                                                    logic [MCNT_W-1:0] em);
        logic [MCNT_W-1:0] d;
        if (em == '0)
            d = '0;
        else if (a >= b)
            d = {1'b0, a} - {1'b0, b};
        else
            d = {1'b0, a} + em - {1'b0, b};
        return d[MIDX_W-1:0];
    endfunction

    // Next slot of the mark ring.
    function automatic logic [MIDX_W-1:0] mark_inc(logic [MIDX_W-1:0] i, logic [MCNT_W-1:0] em);
        logic [MCNT_W-1:0] n;
        n = {1'b0, i} + MCNT_W'(1);
        if (n >= em)
            n = '0;
        return n[MIDX_W-1:0];
    endfunction

endpackage

[hw/rtl/bfm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bfm_ctrl.sv]
// Controller state machine that sequences each item through the datapath.
module bfm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  bfm_pkg::bfm_stat_t stat,
    output bfm_pkg::bfm_cmd_t  cmd
);
    import bfm_pkg::*;

    bfm_state_t state_reg;
    bfm_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.align_needed ? S_ALIGN : S_REPORT;
            end
            S_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (stat.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An alignment step only ever follows an execute step.
    a_align_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALIGN) |-> $past(state_reg == S_EXEC))
        else $error("alignment step without a preceding execute step");

    // Every accepted item reaches execution in the next cycle.
    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted item was not executed");

    // A result is never loaded while the previous one is still held.
    a_report_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |-> stat.out_free)
        else $error("result loaded over a pending result");

endmodule

[hw/rtl/bfm_datapath.sv]
// Datapath: indices, mark ring, byte store and result register.
module bfm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfm_pkg::CFG_W-1:0]     cfg_data,
    input  bfm_pkg::bfm_in_t              item,
    input  bfm_pkg::bfm_cmd_t             cmd,
    output bfm_pkg::bfm_stat_t            stat,
    output bfm_pkg::bfm_out_t             result,
    output logic                          result_valid,
    input  logic                          result_ready
);
    import bfm_pkg::*;

    // Configuration registers, kept as effective values.
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [MCNT_W-1:0] em_reg, em_next;
    logic              align_en_reg, align_en_next;

    // Ring indices.
    logic [IDX_W-1:0]  rd_reg, rd_next;
    logic [IDX_W-1:0]  wr_reg, wr_next;
    logic [IDX_W-1:0]  tent_reg, tent_next;
    logic [MIDX_W-1:0] mrd_reg, mrd_next;
    logic [MIDX_W-1:0] mwr_reg, mwr_next;
    bfm_align_t        align_kind_reg, align_kind_next;
    logic              result_valid_reg, result_valid_next;

    // Item and pending result.
    logic [3:0]        op_reg;
    logic [7:0]        byte_reg;
    logic [31:0]       tag_reg;
    bfm_status_t       status_reg, status_next;
    logic [7:0]        rbyte_reg, rbyte_next;
    logic [31:0]       otag_reg, otag_next;
    bfm_out_t          result_reg, result_next;

    // Mark ring storage.
    logic [IDX_W-1:0]  mark_pos_reg [MARK_DEPTH];
    logic [31:0]       mark_val_reg [MARK_DEPTH];
    logic              mark_we;
    logic [IDX_W-1:0]  mark_pos_wdata;

    // Byte store port.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [7:0]        ram_rdata;

    // Derived values.
    logic [CFG_W:0]    len_round;
    logic [LEN_W-1:0]  len_cfg;
    logic [MCNT_W-1:0] em_cfg;
    logic [IDX_W-1:0]  adv_rd, adv_wr, adv_tent;
    logic [MIDX_W-1:0] mheld, mrd_inc, mwr_inc;
    logic              mspace_zero, marks_empty;
    logic [IDX_W-1:0]  head_pos;
    logic [31:0]       head_val;
    logic [IDX_W-1:0]  held_cur, room_cur;
    logic [IDX_W-1:0]  al_idx, al_limit, al_target;
    logic [1:0]        al_mis;
    logic [2:0]        al_step_raw, al_step;
    logic              al_active;

    bfm_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_reg),
        .raddr (rd_reg),
        .rdata (ram_rdata)
    );

    // Effective configuration values: length rounded up to whole words and clamped.
    assign len_round = ({1'b0, cfg_data} + (CFG_W + 1)'(3)) & ~((CFG_W + 1)'(3));
    assign len_cfg   = (len_round == '0) ? LEN_W'(WORD_BYTES) :
                       (len_round > (CFG_W + 1)'(MAX_LEN)) ? LEN_W'(MAX_LEN) :
                       LEN_W'(len_round);
    assign em_cfg    = (cfg_data[MARK_CFG_W-1:0] > MARK_CFG_W'(MARK_DEPTH)) ?
                       MCNT_W'(MARK_DEPTH) : MCNT_W'(cfg_data[MARK_CFG_W-1:0]);

    // Neighbor indices and mark ring occupancy.
    assign adv_rd      = ring_adv(rd_reg, 3'd1, len_reg);
    assign adv_wr      = ring_adv(wr_reg, 3'd1, len_reg);
    assign adv_tent    = ring_adv(tent_reg, 3'd1, len_reg);
    assign mheld       = mark_dist(mwr_reg, mrd_reg, em_reg);
    assign mrd_inc     = mark_inc(mrd_reg, em_reg);
    assign mwr_inc     = mark_inc(mwr_reg, em_reg);
    assign mspace_zero = (em_reg == '0) || ({1'b0, mheld} == em_reg - MCNT_W'(1));
    assign marks_empty = (em_reg == '0) || (mrd_reg == mwr_reg);
    assign head_pos    = mark_pos_reg[mrd_reg];
    assign head_val    = mark_val_reg[mrd_reg];

    // Byte counts from the current indices.
    assign held_cur = ring_dist(wr_reg, rd_reg, len_reg);
    assign room_cur = IDX_W'(len_reg - LEN_W'(1) - {1'b0, held_cur});

    // Alignment step: move to the next word boundary without passing the other index.
    assign al_idx      = (align_kind_reg == AL_WRITE) ? wr_reg : rd_reg;
    assign al_limit    = (align_kind_reg == AL_WRITE) ? room_cur : held_cur;
    assign al_mis      = al_idx[1:0];
    assign al_step_raw = 3'(WORD_BYTES) - {1'b0, al_mis};
    assign al_step     = ({{(IDX_W - 3){1'b0}}, al_step_raw} > al_limit) ?
                         al_limit[2:0] : al_step_raw;
    assign al_target   = ring_adv(al_idx, al_step, len_reg);
    assign al_active   = align_en_reg && (al_mis != 2'd0) && (align_kind_reg != AL_NONE);

    // Byte store write address follows the operation.
    assign ram_waddr = (op_reg == OP_TENT_BYTE) ? tent_reg : wr_reg;

    // Next state of indices, configuration and pending result.
    always_comb
    begin
        len_next        = len_reg;
        em_next         = em_reg;
        align_en_next   = align_en_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        tent_next       = tent_reg;
        mrd_next        = mrd_reg;
        mwr_next        = mwr_reg;
        align_kind_next = align_kind_reg;
        status_next     = status_reg;
        rbyte_next      = rbyte_reg;
        otag_next       = otag_reg;
        mark_we         = 1'b0;
        mark_pos_wdata  = wr_reg;
        ram_we          = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RING_LENGTH:
                begin
                    len_next = len_cfg;
                end
                CFG_MARK_SLOTS:
                begin
                    em_next = em_cfg;
                end
                CFG_WORD_ALIGN:
                begin
                    align_en_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
            if (cfg_index == CFG_RING_LENGTH || cfg_index == CFG_MARK_SLOTS)
            begin
                rd_next   = '0;
                wr_next   = '0;
                tent_next = '0;
                mrd_next  = '0;
                mwr_next  = '0;
            end
        end
        else if (cmd.exec)
        begin
            status_next     = ST_OK;
            rbyte_next      = '0;
            otag_next       = '0;
            align_kind_next = AL_NONE;
            unique case (op_reg)
                OP_RESET:
                begin
                    rd_next  = '0;
                    wr_next  = '0;
                    mrd_next = '0;
                    mwr_next = '0;
                end
                OP_PUT, OP_PUT_MARKED:
                begin
                    if (op_reg == OP_PUT_MARKED && mspace_zero)
                    begin
                        status_next = ST_MARKS_FULL;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (adv_wr == rd_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_next = adv_wr;
                            if (op_reg == OP_PUT_MARKED)
                            begin
                                mark_we        = 1'b1;
                                mark_pos_wdata = adv_wr;
                                mwr_next       = mwr_inc;
                            end
                        end
                    end
                end
                OP_MARK_HERE:
                begin
                    if (mspace_zero)
                    begin
                        status_next = ST_MARKS_FULL;
                    end
                    else
                    begin
                        mark_we        = 1'b1;
                        mark_pos_wdata = wr_reg;
                        mwr_next       = mwr_inc;
                    end
                end
                OP_GET, OP_PEEK:
                begin
                    if (rd_reg == wr_reg)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rbyte_next = ram_rdata;
                        if (!marks_empty && adv_rd == head_pos)
                        begin
                            status_next = ST_END_OF_MSG;
                            otag_next   = head_val;
                            if (op_reg == OP_GET)
                            begin
                                mrd_next        = mrd_inc;
                                rd_next         = adv_rd;
                                align_kind_next = AL_READ;
                            end
                        end
                        else if (op_reg == OP_GET)
                        begin
                            rd_next = adv_rd;
                        end
                    end
                end
                OP_SKIP_TO_MARK:
                begin
                    if (marks_empty)
                    begin
                        status_next = ST_NO_MARK;
                    end
                    else
                    begin
                        rd_next         = head_pos;
                        otag_next       = head_val;
                        mrd_next        = mrd_inc;
                        align_kind_next = AL_READ;
                    end
                end
                OP_DISCARD:
                begin
                    mrd_next = mwr_reg;
                    rd_next  = wr_reg;
                end
                OP_TENT_BEGIN:
                begin
                    tent_next = wr_reg;
                end
                OP_TENT_BYTE:
                begin
                    ram_we = 1'b1;
                    if (adv_tent == rd_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        tent_next = adv_tent;
                    end
                end
                OP_COMMIT:
                begin
                    wr_next = tent_reg;
                end
                OP_COMMIT_MARKED:
                begin
                    if (mspace_zero)
                    begin
                        status_next = ST_MARKS_FULL;
                    end
                    else
                    begin
                        mark_we         = 1'b1;
                        mark_pos_wdata  = tent_reg;
                        mwr_next        = mwr_inc;
                        wr_next         = tent_reg;
                        align_kind_next = AL_WRITE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.align)
        begin
            if (al_active)
            begin
                if (align_kind_reg == AL_WRITE)
                begin
                    wr_next = al_target;
                end
                else
                begin
                    rd_next = al_target;
                end
            end
        end
    end

    // Result register and its valid flag.
    always_comb
    begin
        result_next            = result_reg;
        result_next.status     = status_reg;
        result_next.read_byte  = rbyte_reg;
        result_next.out_tag    = otag_reg;
        result_next.bytes_held = 10'(held_cur);
        result_next.bytes_free = 10'(room_cur);
        result_next.marks_held = 4'(mheld);
        result_valid_next      = result_valid_reg;
        if (cmd.report)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    assign stat.align_needed = (align_kind_next != AL_NONE);
    assign stat.out_free     = !result_valid_reg || result_ready;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= LEN_W'(MAX_LEN);
            em_reg           <= MCNT_W'(MARK_DEPTH);
            align_en_reg     <= 1'b0;
            rd_reg           <= '0;
            wr_reg           <= '0;
            tent_reg         <= '0;
            mrd_reg          <= '0;
            mwr_reg          <= '0;
            align_kind_reg   <= AL_NONE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg          <= len_next;
            em_reg           <= em_next;
            align_en_reg     <= align_en_next;
            rd_reg           <= rd_next;
            wr_reg           <= wr_next;
            tent_reg         <= tent_next;
            mrd_reg          <= mrd_next;
            mwr_reg          <= mwr_next;
            align_kind_reg   <= align_kind_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: item, pending result, result and mark ring.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= item.operation;
            byte_reg <= item.data_byte;
            tag_reg  <= item.mark_tag;
        end
        status_reg <= status_next;
        rbyte_reg  <= rbyte_next;
        otag_reg   <= otag_next;
        if (cmd.report)
        begin
            result_reg <= result_next;
        end
        if (mark_we)
        begin
            mark_pos_reg[mwr_reg] <= mark_pos_wdata;
            mark_val_reg[mwr_reg] <= tag_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Byte indices always stay inside the ring in use.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, rd_reg} < len_reg) && ({1'b0, wr_reg} < len_reg) &&
        ({1'b0, tent_reg} < len_reg))
        else $error("byte index outside the ring");

    // Mark indices stay inside the mark ring, or at zero when marks are off.
    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((em_reg == '0) && (mrd_reg == '0) && (mwr_reg == '0)) ||
        (({1'b0, mrd_reg} < em_reg) && ({1'b0, mwr_reg} < em_reg)))
        else $error("mark index outside the mark ring");

    // The byte store is written only while an item executes.
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> cmd.exec)
        else $error("byte store written outside execution");

    // A result appears only after a report command.
    a_valid_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(cmd.report))
        else $error("result valid without a report");

endmodule

[hw/rtl/byte_fifo_with_message_marks_top.sv]
// Top level of the byte FIFO with end-of-message marks.
//
//  Channel   Signals                              Transfer
//  item      item_valid, item_ready, item         valid/ready, one operation per item
//  result    result_valid, result_ready, result   valid/ready, one result per item
//  config    cfg_write, cfg_index, cfg_data       write on every cycle cfg_write is high
//
// An item passes through accept, execute and report steps, with an alignment step before the report
// when a mark is consumed or committed, whether or not word alignment is enabled;
// the registered read of the byte store sets the execute step apart from acceptance.
// The next item is accepted while an earlier result still waits in the output register.
// A stalled result holds the controller in its report step until result_ready.
// Reset clears all indices and loads ring length 1024, 16 mark slots, no alignment;
// the byte store and mark ring need no clearing pass.
module byte_fifo_with_message_marks_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  bfm_pkg::bfm_in_t              item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output bfm_pkg::bfm_out_t             result
);
    import bfm_pkg::*;

    bfm_cmd_t  cmd;
    bfm_stat_t stat;

    // Sequencer.
    bfm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Storage and arithmetic.
    bfm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

[tb/byte_fifo_with_message_marks_top_tb.sv]
// Self-checking testbench for the byte FIFO with end-of-message marks.
module byte_fifo_with_message_marks_top_tb;
    import bfm_pkg::*;

    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_ITEMS     = 85;
    localparam int PHASE_COUNT     = 10;
    localparam logic [3:0] OP_SPARE_FIRST = 4'd12;
    localparam logic [3:0] OP_SPARE_LAST  = 4'd15;
    localparam logic [11:0] SINK_PATTERN  = 12'b1110_0011_0100;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_W-1:0]      cfg_data     = '0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    bfm_in_t               item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    bfm_out_t              result;

    // Shadow copy of the FIFO state, updated as each item is accepted.
    logic [7:0]   store_copy [STORE_DEPTH];
    bit           byte_known [STORE_DEPTH];
    int unsigned  mark_at [MARK_DEPTH];
    logic [31:0]  mark_tag_of [MARK_DEPTH];
    int unsigned  rd_pos, wr_pos, tent_pos, mk_rd, mk_wr;
    int unsigned  eff_len   = MAX_LEN;
    int unsigned  eff_marks = MARK_DEPTH;
    bit           align_on  = 1'b0;

    // Results predicted but not yet returned by the block, oldest first.
    bfm_out_t     pending_results [$];
    logic [2:0]   last_status;

    int           errors        = 0;
    int           sent          = 0;
    int           checked       = 0;
    int           settings_used = 0;
    int           cycle_count   = 0;
    bit           sender_gaps   = 1'b0;
    int           sink_mode     = 0;
    int           sink_phase    = 0;
    int unsigned  burst_left    = 0;

    byte_fifo_with_message_marks_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Free-running clock with a period of two time units.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Ring arithmetic on the shadow state.
    function automatic int unsigned ring_step(int unsigned i, int unsigned n);
        int unsigned v;
        v = i + n;
        if (v >= eff_len)
            v -= eff_len;
        return v;
    endfunction

    function automatic int unsigned bytes_queued();
        return (wr_pos >= rd_pos) ? wr_pos - rd_pos : wr_pos + eff_len - rd_pos;
    endfunction

    function automatic int unsigned bytes_room();
        return eff_len - 1 - bytes_queued();
    endfunction

    function automatic int unsigned marks_queued();
        if (eff_marks == 0)
            return 0;
        return (mk_wr >= mk_rd) ? mk_wr - mk_rd : mk_wr + eff_marks - mk_rd;
    endfunction

    function automatic bit no_marks();
        return eff_marks == 0 || mk_rd == mk_wr;
    endfunction

    function automatic int unsigned mark_room();
        if (eff_marks == 0)
            return 0;
        return eff_marks - 1 - marks_queued();
    endfunction

    function automatic void push_mark(int unsigned pos, logic [31:0] tag);
        mark_at[mk_wr] = pos;
        mark_tag_of[mk_wr] = tag;
        mk_wr = (mk_wr + 1 >= eff_marks) ? 0 : mk_wr + 1;
    endfunction

    function automatic logic [31:0] pop_mark();
        logic [31:0] tag;
        tag = mark_tag_of[mk_rd];
        mk_rd = (mk_rd + 1 >= eff_marks) ? 0 : mk_rd + 1;
        return tag;
    endfunction

    // Move the read index to a word boundary without passing the write index.
    function automatic void align_read_index();
        int unsigned step;
        if (align_on && rd_pos % WORD_BYTES != 0)
        begin
            step = WORD_BYTES - rd_pos % WORD_BYTES;
            if (step > bytes_queued())
                step = bytes_queued();
            rd_pos = ring_step(rd_pos, step);
        end
    endfunction

    // Apply one operation to the shadow state and return the result it should give.
    function automatic bfm_out_t apply_operation(bfm_in_t it);
        bfm_out_t    r;
        int unsigned nxt;
        int unsigned step;
        r = '0;
        case (it.operation)
            OP_RESET:
            begin
                rd_pos = 0;
                wr_pos = 0;
                mk_rd = 0;
                mk_wr = 0;
            end
            OP_PUT, OP_PUT_MARKED:
            begin
                if (it.operation == OP_PUT_MARKED && mark_room() == 0)
                    r.status = ST_MARKS_FULL;
                else
                begin
                    store_copy[wr_pos] = it.data_byte;
                    byte_known[wr_pos] = 1'b1;
                    nxt = ring_step(wr_pos, 1);
                    if (nxt == rd_pos)
                        r.status = ST_FULL;
                    else
                    begin
                        wr_pos = nxt;
                        if (it.operation == OP_PUT_MARKED)
                            push_mark(nxt, it.mark_tag);
                    end
                end
            end
            OP_MARK_HERE:
            begin
                if (mark_room() == 0)
                    r.status = ST_MARKS_FULL;
                else
                    push_mark(wr_pos, it.mark_tag);
            end
            OP_GET, OP_PEEK:
            begin
                if (rd_pos == wr_pos)
                    r.status = ST_EMPTY;
                else
                begin
                    r.read_byte = store_copy[rd_pos];
                    nxt = ring_step(rd_pos, 1);
                    if (!no_marks() && nxt == mark_at[mk_rd])
                    begin
                        r.status = ST_END_OF_MSG;
                        if (it.operation == OP_GET)
                        begin
                            r.out_tag = pop_mark();
                            rd_pos = nxt;
                            align_read_index();
                        end
                        else
                            r.out_tag = mark_tag_of[mk_rd];
                    end
                    else if (it.operation == OP_GET)
                        rd_pos = nxt;
                end
            end
            OP_SKIP_TO_MARK:
            begin
                if (no_marks())
                    r.status = ST_NO_MARK;
                else
                begin
                    nxt = mark_at[mk_rd];
                    r.out_tag = pop_mark();
                    rd_pos = nxt;
                    align_read_index();
                end
            end
            OP_DISCARD:
            begin
                mk_rd = mk_wr;
                rd_pos = wr_pos;
            end
            OP_TENT_BEGIN:
                tent_pos = wr_pos;
            OP_TENT_BYTE:
            begin
                store_copy[tent_pos] = it.data_byte;
                byte_known[tent_pos] = 1'b1;
                nxt = ring_step(tent_pos, 1);
                if (nxt == rd_pos)
                    r.status = ST_FULL;
                else
                    tent_pos = nxt;
            end
            OP_COMMIT:
                wr_pos = tent_pos;
            OP_COMMIT_MARKED:
            begin
                if (mark_room() == 0)
                    r.status = ST_MARKS_FULL;
                else
                begin
                    push_mark(tent_pos, it.mark_tag);
                    wr_pos = tent_pos;
                    // The write index moves to a word boundary without passing the free room.
                    if (align_on && wr_pos % WORD_BYTES != 0)
                    begin
                        step = WORD_BYTES - wr_pos % WORD_BYTES;
                        if (step > bytes_room())
                            step = bytes_room();
                        wr_pos = ring_step(wr_pos, step);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.bytes_held = 10'(bytes_queued());
        r.bytes_free = 10'(bytes_room());
        r.marks_held = 4'(marks_queued());
        return r;
    endfunction

    function automatic bfm_in_t op_item(logic [3:0] op, logic [7:0] data, logic [31:0] tag);
        bfm_in_t it;
        it.operation = op;
        it.data_byte = data;
        it.mark_tag = tag;
        return it;
    endfunction

    function automatic bfm_in_t rand_item(logic [3:0] op);
        return op_item(op, 8'($urandom_range(0, 255)), $urandom());
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    // Send one item, with bursts and random gaps when enabled.
    task automatic send_item(bfm_in_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (sender_gaps)
            begin
                gap = $urandom_range(1, 5);
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        // Never read a store entry that has not been written yet.
        if ((it.operation == OP_GET || it.operation == OP_PEEK) && rd_pos != wr_pos
                && !byte_known[rd_pos])
            it.operation = OP_PUT;
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        pending_results.push_back(apply_operation(it));
        last_status = pending_results[$].status;
        sent++;
    endtask

    // Wait until every result is back and the block has settled.
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers while the block is idle.
    task automatic configure(int unsigned len, int unsigned slots, bit align);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_RING_LENGTH;
        cfg_data <= CFG_W'(len);
        @(posedge clk);
        cfg_index <= CFG_MARK_SLOTS;
        cfg_data <= CFG_W'(slots);
        @(posedge clk);
        cfg_index <= CFG_WORD_ALIGN;
        cfg_data <= CFG_W'(align);
        @(posedge clk);
        cfg_write <= 1'b0;
        eff_len = (((len & 32'h7FF) + 3) / WORD_BYTES) * WORD_BYTES;
        if (eff_len < WORD_BYTES)
            eff_len = WORD_BYTES;
        if (eff_len > MAX_LEN)
            eff_len = MAX_LEN;
        eff_marks = slots & 32'h1F;
        if (eff_marks > MARK_DEPTH)
            eff_marks = MARK_DEPTH;
        align_on = align;
        rd_pos = 0;
        wr_pos = 0;
        tent_pos = 0;
        mk_rd = 0;
        mk_wr = 0;
        settings_used++;
    endtask

    task automatic test_empty_after_reset();
        send_item(op_item(OP_GET, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_PEEK, 8'hFF, 32'hFFFF_FFFF));
    endtask

    // Two marks on one position, read back by get, peek and skip.
    task automatic test_messages();
        send_item(op_item(OP_PUT, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_PUT_MARKED, 8'hFF, 32'hFFFF_FFFF));
        send_item(op_item(OP_MARK_HERE, 8'h5A, 32'h8000_0001));
        send_item(op_item(OP_GET, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_PEEK, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_GET, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_SKIP_TO_MARK, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_GET, 8'h00, 32'h0000_0000));
    endtask

    task automatic test_unused_codes();
        send_item(op_item(OP_SPARE_FIRST, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_SPARE_LAST, 8'hFF, 32'hFFFF_FFFF));
    endtask

    // Smallest ring and one mark slot: fill both to the limit.
    task automatic test_full_rings();
        configure(1, 2, 1'b0);
        send_item(op_item(OP_PUT, 8'hA5, 32'h0000_0000));
        send_item(op_item(OP_PUT, 8'h5A, 32'h0000_0000));
        send_item(op_item(OP_PUT, 8'h3C, 32'h0000_0000));
        send_item(op_item(OP_PUT, 8'hC3, 32'h0000_0000));
        send_item(op_item(OP_MARK_HERE, 8'h00, 32'h1234_5678));
        send_item(op_item(OP_PUT_MARKED, 8'h81, 32'h8765_4321));
        send_item(op_item(OP_DISCARD, 8'h00, 32'h0000_0000));
    endtask

    // Tentative writes, word alignment that stops short, and a stale cursor after reset.
    task automatic test_tentative_and_alignment();
        configure(6, 4, 1'b1);
        send_item(op_item(OP_PUT, 8'h11, 32'h0000_0000));
        send_item(op_item(OP_TENT_BEGIN, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_TENT_BYTE, 8'h22, 32'h0000_0000));
        send_item(op_item(OP_COMMIT_MARKED, 8'h00, 32'hCAFE_F00D));
        send_item(op_item(OP_GET, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_GET, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_PUT_MARKED, 8'h33, 32'h0BAD_BEEF));
        send_item(op_item(OP_GET, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_TENT_BEGIN, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_TENT_BYTE, 8'h44, 32'h0000_0000));
        send_item(op_item(OP_RESET, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_COMMIT, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_GET, 8'h00, 32'h0000_0000));
    endtask

    task automatic test_marks_disabled();
        configure(2047, 0, 1'b0);
        send_item(op_item(OP_MARK_HERE, 8'h00, 32'h0000_0001));
        send_item(op_item(OP_SKIP_TO_MARK, 8'h00, 32'h0000_0000));
        send_item(op_item(OP_COMMIT_MARKED, 8'h00, 32'h0000_0002));
    endtask

    // A message of a few bytes, written directly or through the tentative cursor.
    task automatic write_message();
        int unsigned n;
        n = $urandom_range(0, 6);
        if ($urandom_range(0, 2) == 0)
        begin
            send_item(rand_item(OP_TENT_BEGIN));
            repeat (n) send_item(rand_item(OP_TENT_BYTE));
            send_item(rand_item(($urandom_range(0, 3) == 0) ? OP_COMMIT : OP_COMMIT_MARKED));
        end
        else
        begin
            repeat (n) send_item(rand_item(OP_PUT));
            send_item(rand_item(($urandom_range(0, 1) == 0) ? OP_PUT_MARKED : OP_MARK_HERE));
        end
    endtask

    // Read until the end of a message, an empty FIFO, or a few bytes.
    task automatic read_message();
        int unsigned n;
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 3) == 0)
            send_item(rand_item(OP_PEEK));
        repeat (n)
        begin
            send_item(rand_item(OP_GET));
            if (last_status != ST_OK)
                break;
        end
    endtask

    task automatic test_random_traffic();
        int unsigned phase_len   [PHASE_COUNT] = '{8, 4, 12, 16, 2047, 5, 20, 0, 32, 1024};
        int unsigned phase_slots [PHASE_COUNT] = '{4, 2, 3, 16, 31, 1, 0, 5, 8, 16};
        bit          phase_align [PHASE_COUNT] = '{1, 0, 1, 0, 1, 0, 1, 1, 0, 1};
        int          target;
        int unsigned pick;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            configure(phase_len[p], phase_slots[p], phase_align[p]);
            sender_gaps = p[0];
            sink_mode = p % 3;
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    write_message();
                else if (pick < 70)
                    read_message();
                else if (pick < 78)
                    send_item(rand_item(OP_SKIP_TO_MARK));
                else if (pick < 94)
                    send_item(rand_item(4'($urandom_range(0, 15))));
                else
                    send_item(rand_item(OP_DISCARD));
            end
        end
    endtask

    // Compare each returned result with the oldest prediction, and pace result_ready.
    always @(posedge clk)
    begin
        bfm_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0h", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                check_field("status", want.status, result.status);
                check_field("read_byte", want.read_byte, result.read_byte);
                check_field("out_tag", want.out_tag, result.out_tag);
                check_field("bytes_held", want.bytes_held, result.bytes_held);
                check_field("bytes_free", want.bytes_free, result.bytes_free);
                check_field("marks_held", want.marks_held, result.marks_held);
            end
        end
        case (sink_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= ($urandom_range(0, 2) != 0);
            default: result_ready <= SINK_PATTERN[sink_phase];
        endcase
        sink_phase <= (sink_phase == 11) ? 0 : sink_phase + 1;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Reset once, then run the tests in turn.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_after_reset();
        test_messages();
        test_unused_codes();
        test_full_rings();
        test_tentative_and_alignment();
        test_marks_disabled();
        test_random_traffic();
        drain();
        $display("Sent %0d operations under %0d register settings and compared %0d results.",
                 sent, settings_used, checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bfm_pkg.sv
hw/rtl/bfm_ram.sv
hw/rtl/bfm_ctrl.sv
hw/rtl/bfm_datapath.sv
hw/rtl/byte_fifo_with_message_marks_top.sv
tb/byte_fifo_with_message_marks_top_tb.sv
